/* src/stt_pkg.sv */
// Shared types, codes and character classes for the source text tokenizer.
`default_nettype none

package stt_pkg;

  // Scanner mode between bytes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_IDENT  = 3'd2,
    MODE_STRING = 3'd3,
    MODE_MINUS  = 3'd4
  } scan_mode_t;

  // Keyword match progress for "fn"
  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_F    = 2'd1;
  localparam logic [1:0] KW_FN   = 2'd2;

  // Token kinds
  localparam logic [4:0] K_EOF       = 5'd0;
  localparam logic [4:0] K_NUMBER    = 5'd1;
  localparam logic [4:0] K_STRING    = 5'd2;
  localparam logic [4:0] K_IDENT     = 5'd3;
  localparam logic [4:0] K_FN        = 5'd4;
  localparam logic [4:0] K_ANON      = 5'd5;
  localparam logic [4:0] K_SEMI      = 5'd6;
  localparam logic [4:0] K_COLON     = 5'd7;
  localparam logic [4:0] K_LBRACE    = 5'd8;
  localparam logic [4:0] K_RBRACE    = 5'd9;
  localparam logic [4:0] K_LPAREN    = 5'd10;
  localparam logic [4:0] K_RPAREN    = 5'd11;
  localparam logic [4:0] K_PLUS      = 5'd12;
  localparam logic [4:0] K_STAR      = 5'd13;
  localparam logic [4:0] K_SLASH     = 5'd14;
  localparam logic [4:0] K_EQUAL     = 5'd15;
  localparam logic [4:0] K_MINUS     = 5'd16;
  localparam logic [4:0] K_ARROW     = 5'd17;
  localparam logic [4:0] K_UNMATCHED = 5'd18;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One result token
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] stop;
    logic        last;
  } token_t;

  function automatic logic is_number_byte(input logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || b == CH_DOT;
  endfunction

  function automatic logic is_ident_byte(input logic [7:0] b);
    return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) ||
           (b >= CH_0 && b <= CH_9) || b == CH_UNDER;
  endfunction

  function automatic logic is_space_byte(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF;
  endfunction

  // Single-byte punctuation kind, K_EOF when the byte is not punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    k = K_EOF;
    unique case (b)
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_PLUS:   k = K_PLUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_EQUAL:  k = K_EQUAL;
      default:   k = K_EOF;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/source_text_tokenizer_core.sv */
// Source text tokenizer: byte scanner with a four-entry result queue.
// Each token is written into the registered result queue when its byte is accepted.
// Throughput: one byte per cycle while the queue has room for two tokens (required to
// accept); a byte that ends two tokens fills two entries, so the queue sets the rate.
// Reset: synchronous active-low rst_n returns the scanner to idle at offset zero and
// empties the result queue.
`default_nettype none

module source_text_tokenizer_core #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_end,
  output logic             out_last_of_run
);
  import stt_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_ONE = {{(PB-1){1'b0}}, 1'b1};

  // Scanner state
  scan_mode_t    mode_r, mode_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] pend_r, pend_nxt;
  logic [1:0]    kw_r, kw_nxt;
  logic          held_v_r, held_v_nxt;
  logic [PB-1:0] held_s_r, held_s_nxt;
  logic [PB-1:0] held_e_r, held_e_nxt;

  // Result queue
  token_t      q_mem_r [4];
  logic [1:0]  q_wr_r, q_rd_r;
  logic [2:0]  q_cnt_r;

  logic        accept, pop;
  logic [7:0]  b;
  logic [PB-1:0] p, p_inc;
  token_t      tok_a, tok_b1, tok_b2, slot0, slot1;
  logic        a_v, b1_v, b2_v;
  logic [1:0]  n_res;

  assign in_ready  = (q_cnt_r <= 3'd2);
  assign accept    = in_valid && in_ready;
  assign out_valid = (q_cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;

  assign b     = in_text_byte;
  assign p     = pos_r;
  assign p_inc = pos_r + POS_ONE;

  // Scan one byte: phase A closes the open token, phase B starts the next one
  always_comb begin
    logic run_start, restart;
    logic [4:0] pk;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    kw_nxt     = kw_r;
    held_v_nxt = held_v_r;
    held_s_nxt = held_s_r;
    held_e_nxt = held_e_r;
    a_v  = 1'b0;
    b1_v = 1'b0;
    b2_v = 1'b0;
    tok_a  = '0;
    tok_b1 = '0;
    tok_b2 = '0;
    run_start = 1'b0;
    restart   = 1'b0;
    pk = punct_kind(b);

    unique case (mode_r)
      MODE_NUMBER: begin
        if (!is_number_byte(b)) begin
          a_v = 1'b1;
          tok_a = '{K_NUMBER, 16'(pend_r), 16'(p), 1'b0};
          mode_nxt = MODE_IDLE;
          run_start = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_ident_byte(b)) begin
          kw_nxt = (kw_r == KW_F && b == CH_LC_N) ? KW_FN : KW_NONE;
        end else begin
          if (kw_r == KW_FN) begin
            held_v_nxt = 1'b1;
            held_s_nxt = pend_r;
            held_e_nxt = p;
          end else begin
            a_v = 1'b1;
            tok_a = '{K_IDENT, 16'(pend_r), 16'(p), 1'b0};
          end
          kw_nxt = KW_NONE;
          mode_nxt = MODE_IDLE;
          run_start = 1'b1;
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          a_v = 1'b1;
          tok_a = '{K_STRING, 16'(pend_r + POS_ONE), 16'(p), 1'b0};
          mode_nxt = MODE_IDLE;
        end else if (b == CH_NUL) begin
          a_v = 1'b1;
          tok_a = '{K_UNMATCHED, 16'(pend_r + POS_ONE), 16'(p), 1'b0};
          restart = 1'b1;
        end
      end
      MODE_MINUS: begin
        mode_nxt = MODE_IDLE;
        a_v = 1'b1;
        if (b == CH_GT) begin
          tok_a = '{K_ARROW, 16'(pend_r), 16'(p_inc), 1'b0};
        end else begin
          tok_a = '{K_MINUS, 16'(pend_r), 16'(p), 1'b0};
          run_start = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        run_start = 1'b1;
      end
    endcase

    // Start a token on this byte, flushing a held fn first
    if (run_start && !is_space_byte(b)) begin
      if (held_v_nxt && b == CH_COLON) begin
        held_v_nxt = 1'b0;
        b1_v = 1'b1;
        tok_b1 = '{K_ANON, 16'(held_s_nxt), 16'(p_inc), 1'b0};
      end else begin
        if (held_v_nxt) begin
          held_v_nxt = 1'b0;
          b1_v = 1'b1;
          tok_b1 = '{K_FN, 16'(held_s_nxt), 16'(held_e_nxt), 1'b0};
        end
        if (b == CH_NUL) begin
          b2_v = 1'b1;
          tok_b2 = '{K_EOF, 16'(p), 16'(p), 1'b0};
          restart = 1'b1;
        end else begin
          pend_nxt = p;
          if (is_number_byte(b)) begin
            mode_nxt = MODE_NUMBER;
          end else if (b == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
          end else if (b == CH_MINUS) begin
            mode_nxt = MODE_MINUS;
          end else if (pk != K_EOF) begin
            b2_v = 1'b1;
            tok_b2 = '{pk, 16'(p), 16'(p_inc), 1'b0};
          end else begin
            mode_nxt = MODE_IDENT;
            kw_nxt = (b == CH_LC_F) ? KW_F : KW_NONE;
          end
        end
      end
    end

    // Return to reset after end of text, else advance the offset
    if (restart) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      pend_nxt   = '0;
      kw_nxt     = KW_NONE;
      held_v_nxt = 1'b0;
      held_s_nxt = '0;
      held_e_nxt = '0;
    end else begin
      pos_nxt = p_inc;
    end
  end

  // Pack up to two tokens into queue slots and mark the final one
  always_comb begin
    n_res = 2'({1'b0, a_v} + {1'b0, b1_v} + {1'b0, b2_v});
    if (a_v) begin
      slot0 = tok_a;
      slot1 = b1_v ? tok_b1 : tok_b2;
    end else if (b1_v) begin
      slot0 = tok_b1;
      slot1 = tok_b2;
    end else begin
      slot0 = tok_b2;
      slot1 = tok_b2;
    end
    slot0.last = (n_res == 2'd1);
    slot1.last = 1'b1;
  end

  // Hold scanner state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      pend_r   <= '0;
      kw_r     <= KW_NONE;
      held_v_r <= 1'b0;
      held_s_r <= '0;
      held_e_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
      kw_r     <= kw_nxt;
      held_v_r <= held_v_nxt;
      held_s_r <= held_s_nxt;
      held_e_r <= held_e_nxt;
    end
  end

  // Write result tokens into the queue
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      q_mem_r[q_wr_r] <= slot0;
    end
    if (accept && n_res == 2'd2) begin
      q_mem_r[q_wr_r + 2'd1] <= slot1;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (accept) begin
        q_wr_r <= q_wr_r + n_res;
      end
      if (pop) begin
        q_rd_r <= q_rd_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + (accept ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  // Drive the head of the queue
  assign out_token_kind  = q_mem_r[q_rd_r].kind;
  assign out_token_start = q_mem_r[q_rd_r].start;
  assign out_token_end   = q_mem_r[q_rd_r].stop;
  assign out_last_of_run = q_mem_r[q_rd_r].last;

endmodule

`default_nettype wire
